FILE: design/vrt_pkg.sv
// Package of shared types and constants for the voxel ray traversal unit.
package vrt_pkg;

   localparam int unsigned MAX_RESULTS = 46;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);
   localparam int unsigned CELL_W      = 4;
   localparam int unsigned COORD_W     = 7;
   localparam int unsigned POS_W       = 8;
   localparam int unsigned AD_W        = 7;
   localparam int unsigned K_W         = 6;
   localparam int unsigned ODD_W       = K_W + 1;
   localparam int unsigned CROSS_W     = ODD_W + AD_W;
   localparam int unsigned DIST_W      = 12;
   localparam int unsigned STEP_W      = 16;
   localparam int unsigned SIZE_W      = 5;
   localparam int unsigned SQ_W        = 2 * STEP_W;
   localparam int unsigned PROD_W      = DIST_W + SQ_W;
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned ADDR_W      = 4;

   localparam logic [STEP_W-1:0] GRID_STEP_RESET = 16'd256;
   localparam logic [SIZE_W-1:0] SIZE_RESET      = 5'd16;

   typedef enum logic [1:0] {
      REG_GRID_STEP = 2'd0,
      REG_SIZE_X    = 2'd1,
      REG_SIZE_Y    = 2'd2,
      REG_SIZE_Z    = 2'd3
   } reg_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } ctrl_state_type;

   typedef struct packed {
      logic [STEP_W-1:0] grid_step;
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [SIZE_W-1:0] size_z;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

FILE: design/vrt_csr.sv
// Configuration register file with its APB-style access port.
module vrt_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [vrt_pkg::ADDR_W-1:0]  paddr,
   input  logic [vrt_pkg::DATA_W-1:0]  pwdata,
   output logic [vrt_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output vrt_pkg::cfg_type            cfg
);
   import vrt_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:2]);
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_GRID_STEP: cfg_in.grid_step = pwdata[STEP_W-1:0];
            REG_SIZE_X:    cfg_in.size_x    = pwdata[SIZE_W-1:0];
            REG_SIZE_Y:    cfg_in.size_y    = pwdata[SIZE_W-1:0];
            REG_SIZE_Z:    cfg_in.size_z    = pwdata[SIZE_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_GRID_STEP: prdata = DATA_W'(cfg_ff.grid_step);
         REG_SIZE_X:    prdata = DATA_W'(cfg_ff.size_x);
         REG_SIZE_Y:    prdata = DATA_W'(cfg_ff.size_y);
         REG_SIZE_Z:    prdata = DATA_W'(cfg_ff.size_z);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_step <= GRID_STEP_RESET;
         cfg_ff.size_x    <= SIZE_RESET;
         cfg_ff.size_y    <= SIZE_RESET;
         cfg_ff.size_z    <= SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/vrt_ctrl.sv
// Controller state machine that sequences one ray and owns the result valid.
module vrt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  vrt_pkg::status_type   status,
   output vrt_pkg::cmd_type      cmd
);
   import vrt_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/vrt_datapath.sv
// Datapath that holds the ray state, chooses the step axis and fills the result register.
module vrt_datapath #(
   parameter int unsigned GRID_X = 16,
   parameter int unsigned GRID_Y = 16,
   parameter int unsigned GRID_Z = 16
) (
   input  logic                               clock,
   input  vrt_pkg::cfg_type                   cfg,
   input  vrt_pkg::cmd_type                   cmd,
   output vrt_pkg::status_type                status,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_start_z,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_end_y,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_end_z,
   input  logic [vrt_pkg::STEP_W-1:0]         req_limit_radius,
   output logic [vrt_pkg::CELL_W-1:0]         rsp_cell_x,
   output logic [vrt_pkg::CELL_W-1:0]         rsp_cell_y,
   output logic [vrt_pkg::CELL_W-1:0]         rsp_cell_z,
   output logic                               rsp_last,
   output logic                               rsp_start_error
);
   import vrt_pkg::*;

   localparam logic [SIZE_W-1:0] CAP_X = SIZE_W'(GRID_X);
   localparam logic [SIZE_W-1:0] CAP_Y = SIZE_W'(GRID_Y);
   localparam logic [SIZE_W-1:0] CAP_Z = SIZE_W'(GRID_Z);

   // Ray state.
   logic signed [POS_W-1:0] cur_ff [3];
   logic signed [POS_W-1:0] end_ff [3];
   logic [AD_W-1:0]         ad_ff [3];
   logic                    dir_neg_ff [3];
   logic [K_W-1:0]          k_ff [3];
   logic [DIST_W-1:0]       dist2_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [SQ_W-1:0]         r2_ff;
   logic [SQ_W-1:0]         g2_ff;
   logic                    rad_zero_ff;
   logic                    err_ff;
   logic                    eq_ff;

   // Result register.
   logic [CELL_W-1:0]       cell_ff [3];
   logic                    last_ff;
   logic                    start_error_ff;

   logic [SIZE_W-1:0]       size_cap [3];
   logic signed [POS_W-1:0] start_pos [3];
   logic signed [POS_W-1:0] end_pos [3];
   logic signed [POS_W-1:0] delta [3];
   logic [AD_W-1:0]         ad_in [3];
   logic [2:0]              start_bad;
   logic [2:0]              start_eq;
   logic                    e01;
   logic                    e02;
   logic                    e12;
   logic [2:0]              sel;
   logic signed [POS_W-1:0] step_pos [3];
   logic signed [POS_W-1:0] next_pos [3];
   logic [K_W-1:0]          next_k [3];
   logic [ODD_W-1:0]        odd_sel;
   logic [DIST_W-1:0]       next_dist2;
   logic [2:0]              next_eq;
   logic [2:0]              next_bad;
   logic [PROD_W-1:0]       radius_prod;
   logic                    radius_hit;
   logic                    cap_hit;

   // The next face crossing of axis i comes strictly before that of axis j.
   function automatic logic earlier(input logic [AD_W-1:0] ad_i, input logic [AD_W-1:0] ad_j,
                                    input logic [K_W-1:0] k_i, input logic [K_W-1:0] k_j);
      logic [CROSS_W-1:0] lhs;
      logic [CROSS_W-1:0] rhs;
      lhs = CROSS_W'({k_i, 1'b1}) * CROSS_W'(ad_j);
      rhs = CROSS_W'({k_j, 1'b1}) * CROSS_W'(ad_i);
      if (ad_i == '0) begin
         earlier = 1'b0;
      end else if (ad_j == '0) begin
         earlier = 1'b1;
      end else begin
         earlier = lhs < rhs;
      end
   endfunction

   always_comb begin
      size_cap[0] = (cfg.size_x < CAP_X) ? cfg.size_x : CAP_X;
      size_cap[1] = (cfg.size_y < CAP_Y) ? cfg.size_y : CAP_Y;
      size_cap[2] = (cfg.size_z < CAP_Z) ? cfg.size_z : CAP_Z;
      start_pos[0] = {req_start_x[COORD_W-1], req_start_x};
      start_pos[1] = {req_start_y[COORD_W-1], req_start_y};
      start_pos[2] = {req_start_z[COORD_W-1], req_start_z};
      end_pos[0]   = {req_end_x[COORD_W-1], req_end_x};
      end_pos[1]   = {req_end_y[COORD_W-1], req_end_y};
      end_pos[2]   = {req_end_z[COORD_W-1], req_end_z};
      for (int i = 0; i < 3; i++) begin
         delta[i]     = end_pos[i] - start_pos[i];
         ad_in[i]     = delta[i][POS_W-1] ? AD_W'(-delta[i]) : AD_W'(delta[i]);
         start_bad[i] = start_pos[i][POS_W-1] ||
                        (start_pos[i] >= $signed({3'b000, size_cap[i]}));
         start_eq[i]  = start_pos[i] == end_pos[i];
      end
   end

   always_comb begin
      e01 = earlier(ad_ff[0], ad_ff[1], k_ff[0], k_ff[1]);
      e02 = earlier(ad_ff[0], ad_ff[2], k_ff[0], k_ff[2]);
      e12 = earlier(ad_ff[1], ad_ff[2], k_ff[1], k_ff[2]);
      sel[0] = e01 && e02;
      sel[1] = !e01 && e12;
      sel[2] = e01 ? !e02 : !e12;
      odd_sel = '0;
      for (int i = 0; i < 3; i++) begin
         if (ad_ff[i] == '0) begin
            step_pos[i] = '0;
         end else if (dir_neg_ff[i]) begin
            step_pos[i] = -POS_W'(1);
         end else begin
            step_pos[i] = POS_W'(1);
         end
         next_pos[i] = sel[i] ? (cur_ff[i] + step_pos[i]) : cur_ff[i];
         next_k[i]   = sel[i] ? (k_ff[i] + K_W'(1)) : k_ff[i];
         if (sel[i]) begin
            odd_sel = {k_ff[i], 1'b1};
         end
         next_eq[i]  = next_pos[i] == end_ff[i];
         next_bad[i] = next_pos[i][POS_W-1] ||
                       (next_pos[i] >= $signed({3'b000, size_cap[i]}));
      end
      next_dist2  = dist2_ff + DIST_W'(odd_sel);
      radius_prod = PROD_W'(dist2_ff) * PROD_W'(g2_ff);
      radius_hit  = !rad_zero_ff && (radius_prod > PROD_W'(r2_ff));
      cap_hit     = cnt_ff == CNT_W'(MAX_RESULTS - 1);
      status.last = err_ff || eq_ff || radius_hit || cap_hit || (&next_eq) || (|next_bad);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            cur_ff[i]     <= start_pos[i];
            end_ff[i]     <= end_pos[i];
            ad_ff[i]      <= ad_in[i];
            dir_neg_ff[i] <= delta[i][POS_W-1];
            k_ff[i]       <= '0;
         end
         dist2_ff    <= '0;
         cnt_ff      <= '0;
         r2_ff       <= SQ_W'(req_limit_radius) * SQ_W'(req_limit_radius);
         g2_ff       <= SQ_W'(cfg.grid_step) * SQ_W'(cfg.grid_step);
         rad_zero_ff <= req_limit_radius == '0;
         err_ff      <= |start_bad;
         eq_ff       <= &start_eq;
      end
      if (cmd.emit) begin
         for (int i = 0; i < 3; i++) begin
            cell_ff[i] <= err_ff ? '0 : cur_ff[i][CELL_W-1:0];
         end
         last_ff        <= status.last;
         start_error_ff <= err_ff;
         if (!status.last) begin
            for (int i = 0; i < 3; i++) begin
               cur_ff[i] <= next_pos[i];
               k_ff[i]   <= next_k[i];
            end
            dist2_ff <= next_dist2;
            cnt_ff   <= cnt_ff + CNT_W'(1);
         end
      end
   end

   assign rsp_cell_x      = cell_ff[0];
   assign rsp_cell_y      = cell_ff[1];
   assign rsp_cell_z      = cell_ff[2];
   assign rsp_last        = last_ff;
   assign rsp_start_error = start_error_ff;

endmodule

FILE: design/voxel_ray_traversal_3d_unit.sv
// Top level of the 3D voxel ray traversal unit.
// An accepted item loads the ray state and moves the controller to its walk state; the first result
// is registered into the result register once the output is free. A ray then yields one cell per cycle while
// results are taken, up to 46 results per ray, and no new item is taken until its last result has been emitted.
// Reset returns the controller to idle, drops the result valid and loads the register defaults.
module voxel_ray_traversal_3d_unit #(
   parameter int unsigned GRID_X = 16,
   parameter int unsigned GRID_Y = 16,
   parameter int unsigned GRID_Z = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_start_z,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_end_y,
   input  logic signed [vrt_pkg::COORD_W-1:0] req_end_z,
   input  logic [vrt_pkg::STEP_W-1:0]         req_limit_radius,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [vrt_pkg::CELL_W-1:0]         rsp_cell_x,
   output logic [vrt_pkg::CELL_W-1:0]         rsp_cell_y,
   output logic [vrt_pkg::CELL_W-1:0]         rsp_cell_z,
   output logic                               rsp_last,
   output logic                               rsp_start_error,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [vrt_pkg::ADDR_W-1:0]         paddr,
   input  logic [vrt_pkg::DATA_W-1:0]         pwdata,
   output logic [vrt_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);
   import vrt_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   vrt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vrt_datapath #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_datapath (
      .clock            (clock),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_start_z      (req_start_z),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_end_z        (req_end_z),
      .req_limit_radius (req_limit_radius),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_cell_z       (rsp_cell_z),
      .rsp_last         (rsp_last),
      .rsp_start_error  (rsp_start_error)
   );

`ifndef NO_ASSERTIONS
   a_error_item_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_error |->
         rsp_last && rsp_cell_x == '0 && rsp_cell_y == '0 && rsp_cell_z == '0)
      else $error("Error item is not a lone zero item with last set.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A new item was offered ready straight after acceptance.");

   a_result_while_walking: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("A result appeared without a ray in progress.");
`endif

endmodule
